// ----- design/pse_pkg.sv -----
// shared types and constants of the postfix stack evaluator
// used by pse_arith, postfix_stack_evaluator_unit and its testbench; no dependencies
package pse_pkg;

   localparam int DATA_W          = 64;
   localparam int STACK_DEPTH_DEF = 64;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_MUL    = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_MOD    = 3'd5;
   localparam logic [2:0] OP_FINISH = 3'd6;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MALFORMED = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_DIVZERO   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic start;
      logic is_div;
   } arith_cmd_type;

endpackage

// ----- design/postfix_stack_evaluator_unit.sv -----
// Postfix evaluator with signed 64-bit arithmetic and sticky error status.
// The request channel (req_) takes one token a request: tuser is the
// operator code, tdata the operand pushed by a push token. The result
// channel (rsp_) gives one result for each finish token: the value and a
// status, after which the stack and the error state are cleared.
// The top of the stack sits in a register, the entries below it in a
// synchronous single-port memory of STACK_DEPTH words.
// Push, finish and ignored tokens are handled in the idle state. Add and
// subtract take a memory read and then execute. Multiply runs on the
// four-step partial product multiplier; divide and modulo run on the
// one-bit-per-cycle shared divider.
// Reset clears the depth, the error state and the result valid flag; the
// memory needs no clearing. A finished result is held in an output register
// while the receiver stalls; other requests are still taken while it waits,
// and only a finish request is held back until the waiting result has been
// taken or is taken in the same cycle.
module postfix_stack_evaluator_unit import pse_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_value
   input  logic [2:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // result_value, status, zero padding
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_WAIT = 3'b100
   } state_type;

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [2:0]        err_ff, err_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [DATA_W-1:0] left_ff;
   logic [2:0]        op_ff, op_in;
   logic              neg_ff, neg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CW-1:0]     cnt_m1, cnt_m2;

   arith_cmd_type       cmd;
   logic [DATA_W-1:0]   a_mag, b_mag;
   logic                ar_done;
   logic [2*DATA_W-1:0] ar_prod;
   logic [DATA_W-1:0]   ar_quo, ar_rem;

   logic [DATA_W-1:0]   left, right, sum, dif, res, rn, modsum;
   logic                lneg, rneg;
   logic [2*DATA_W-1:0] limit;

   assign req_tready = (state_ff == S_IDLE)
                       && (req_tuser != OP_FINISH || !rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign cnt_m1     = count_ff - CW'(1);
   assign cnt_m2     = count_ff - CW'(2);
   assign wr_addr    = cnt_m1[AW-1:0];
   assign rd_addr    = cnt_m2[AW-1:0];

   always_comb begin
      left   = left_ff;
      right  = tos_ff;
      lneg   = left[DATA_W-1];
      rneg   = right[DATA_W-1];
      a_mag  = lneg ? (DATA_W'(0) - left) : left;
      b_mag  = rneg ? (DATA_W'(0) - right) : right;
      sum    = left + right;
      dif    = left - right;
      limit  = neg_ff ? {64'd0, 64'h8000_0000_0000_0000}
                      : {64'd0, 64'h7fff_ffff_ffff_ffff};
      rn     = lneg ? (DATA_W'(0) - ar_rem) : ar_rem;
      modsum = right + rn;
      res    = '0;

      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      tos_in        = tos_ff;
      op_in         = op_ff;
      neg_in        = neg_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      cmd           = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_tuser;
               if (req_tuser == OP_FINISH) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = err_ff;
                  if (err_ff == ST_OK) begin
                     if (count_ff == CW'(1)) begin
                        rsp_value_in = tos_ff;
                     end else begin
                        rsp_status_in = ST_MALFORMED;
                     end
                  end
                  count_in = '0;
                  err_in   = ST_OK;
               end else if (req_tuser == OP_UNUSED || err_ff != ST_OK) begin
                  op_in = op_ff;
               end else if (req_tuser == OP_PUSH) begin
                  if (count_ff >= DEPTH_C) begin
                     err_in = ST_FULL;
                  end else begin
                     wr_en    = (count_ff != '0);
                     tos_in   = req_tdata;
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff < CW'(2)) begin
                  err_in = ST_MALFORMED;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            neg_in   = lneg ^ rneg;
            case (op_ff)
               OP_ADD: begin
                  if (((left ^ sum) & (right ^ sum)) >> (DATA_W - 1) != '0) begin
                     err_in = ST_OVERFLOW;
                  end else begin
                     tos_in   = sum;
                     count_in = cnt_m1;
                  end
               end
               OP_SUB: begin
                  if (((left ^ right) & (left ^ dif)) >> (DATA_W - 1) != '0) begin
                     err_in = ST_OVERFLOW;
                  end else begin
                     tos_in   = dif;
                     count_in = cnt_m1;
                  end
               end
               OP_MUL: begin
                  cmd.start = 1'b1;
                  state_in  = S_WAIT;
               end
               default: begin
                  if (right == '0) begin
                     err_in = ST_DIVZERO;
                  end else if (op_ff == OP_DIV && left == 64'h8000_0000_0000_0000
                               && right == '1) begin
                     err_in = ST_OVERFLOW;
                  end else begin
                     cmd.start  = 1'b1;
                     cmd.is_div = 1'b1;
                     state_in   = S_WAIT;
                  end
               end
            endcase
         end
         S_WAIT: begin
            if (ar_done) begin
               state_in = S_IDLE;
               case (op_ff)
                  OP_MUL: begin
                     res = neg_ff ? (DATA_W'(0) - ar_prod[DATA_W-1:0])
                                  : ar_prod[DATA_W-1:0];
                     if (ar_prod > limit) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        tos_in   = res;
                        count_in = cnt_m1;
                     end
                  end
                  OP_DIV: begin
                     tos_in   = neg_ff ? (DATA_W'(0) - ar_quo) : ar_quo;
                     count_in = cnt_m1;
                  end
                  default: begin
                     if (lneg && (((right ^ modsum) & (rn ^ modsum)) >> (DATA_W - 1)
                                  != '0)) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        tos_in   = lneg ? modsum : ar_rem;
                        count_in = cnt_m1;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= tos_ff;
      end
      if (rd_en) begin
         left_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tos_ff        <= tos_in;
      op_ff         <= op_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   pse_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .a_mag (a_mag),
      .b_mag (b_mag),
      .done  (ar_done),
      .prod  (ar_prod),
      .quo   (ar_quo),
      .rem   (ar_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_value_ff};

endmodule

// ----- design/pse_arith.sv -----
// iterative magnitude multiplier (four 32x32 partial products) and
// restoring divider (one quotient bit per cycle); uses pse_pkg
module pse_arith import pse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  arith_cmd_type         cmd,
   input  logic [DATA_W-1:0]     a_mag,
   input  logic [DATA_W-1:0]     b_mag,
   output logic                  done,
   output logic [2*DATA_W-1:0]   prod,
   output logic [DATA_W-1:0]     quo,
   output logic [DATA_W-1:0]     rem
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                is_div_ff, is_div_in;
   logic [5:0]          step_ff, step_in;
   logic [DATA_W-1:0]   a_ff, a_in;
   logic [DATA_W-1:0]   b_ff, b_in;
   logic [2*DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;

   logic [31:0]         a_half, b_half;
   logic [63:0]         pp;
   logic [6:0]          shamt;
   logic [DATA_W:0]     trial, diff;
   logic                ge;
   logic                last;

   always_comb begin
      a_half = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half = step_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_half * b_half;
      shamt  = ({6'd0, step_ff[0]} + {6'd0, step_ff[1]}) << 5;
      trial  = {rem_ff, quo_ff[DATA_W-1]};
      diff   = trial - {1'b0, b_ff};
      ge     = (trial >= {1'b0, b_ff});
      last   = is_div_ff ? (step_ff == 6'd63) : (step_ff == 6'd3);

      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      step_in   = step_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         is_div_in = cmd.is_div;
         step_in   = 6'd0;
         a_in      = a_mag;
         b_in      = b_mag;
         acc_in    = '0;
         quo_in    = a_mag;
         rem_in    = '0;
      end else if (busy_ff) begin
         if (is_div_ff) begin
            rem_in = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], ge};
         end else begin
            acc_in = acc_ff + ({64'd0, pp} << shamt);
         end
         step_in = step_ff + 6'd1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      step_ff   <= step_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// ----- dv/postfix_stack_evaluator_unit_tb.sv -----
// self-checking testbench for postfix_stack_evaluator_unit
// tokens go in on req_, results are checked on rsp_ against a local evaluator model
// depends on pse_pkg and the design sources
module postfix_stack_evaluator_unit_tb;
   import pse_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  status;
   } eval_result_type;

   logic [63:0]     eval_stack [DEPTH];
   int              eval_depth;
   logic [2:0]      eval_error;
   eval_result_type pending_results [$];
   int              error_count;
   int              token_count;
   int              finish_count;
   int              status_seen [8];
   bit              stall_enable;

   postfix_stack_evaluator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] magn(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [2:0] arith_step(logic [2:0] op, logic [63:0] lft,
                                             logic [63:0] rgt, output logic [63:0] res);
      logic [63:0] ul, ur, q, r, lim;
      logic        neg;
      ul  = magn(lft);
      ur  = magn(rgt);
      res = '0;
      case (op)
         OP_ADD: begin
            res = lft + rgt;
            return (((lft ^ res) & (rgt ^ res)) >> 63) ? ST_OVERFLOW : ST_OK;
         end
         OP_SUB: begin
            res = lft - rgt;
            return (((lft ^ rgt) & (lft ^ res)) >> 63) ? ST_OVERFLOW : ST_OK;
         end
         OP_MUL: begin
            res = lft * rgt;
            neg = lft[63] ^ rgt[63];
            lim = neg ? MIN_VAL : MAX_VAL;
            if (ul == 0 || ur == 0) return ST_OK;
            return (ul > lim / ur) ? ST_OVERFLOW : ST_OK;
         end
         default: ;
      endcase
      if (rgt == 0) return ST_DIVZERO;
      if (op == OP_DIV) begin
         if (lft == MIN_VAL && rgt == '1) return ST_OVERFLOW;
         q   = ul / ur;
         res = (lft[63] != rgt[63]) ? -q : q;
         return ST_OK;
      end
      r = ul % ur;
      if (lft[63]) begin
         r   = -r;
         res = rgt + r;
         return (((rgt ^ res) & (r ^ res)) >> 63) ? ST_OVERFLOW : ST_OK;
      end
      res = r;
      return ST_OK;
   endfunction

   task automatic evaluate_token(logic [2:0] op, logic [63:0] val);
      eval_result_type rr;
      logic [63:0]     res;
      logic [2:0]      st;
      if (op == OP_FINISH) begin
         rr.status = eval_error;
         rr.value  = '0;
         if (eval_error == ST_OK) begin
            if (eval_depth == 1) rr.value = eval_stack[0];
            else rr.status = ST_MALFORMED;
         end
         pending_results.push_back(rr);
         eval_depth = 0;
         eval_error = ST_OK;
         return;
      end
      if (op == OP_UNUSED || eval_error != ST_OK) return;
      if (op == OP_PUSH) begin
         if (eval_depth >= DEPTH) eval_error = ST_FULL;
         else begin
            eval_stack[eval_depth] = val;
            eval_depth++;
         end
         return;
      end
      if (eval_depth < 2) begin
         eval_error = ST_MALFORMED;
         return;
      end
      st = arith_step(op, eval_stack[eval_depth-2], eval_stack[eval_depth-1], res);
      if (st != ST_OK) eval_error = st;
      else begin
         eval_depth--;
         eval_stack[eval_depth-1] = res;
      end
   endtask

   // idle the request side for a while, valid drops only when there is a gap
   task automatic random_gap(int scale);
      int n;
      n = 0;
      if ($urandom_range(0, 99) < scale)
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // drive one token and wait for its acceptance
   task automatic send_token(logic [2:0] op, logic [63:0] val);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      evaluate_token(op, val);
      token_count++;
      @(negedge clock);
      random_gap(stall_enable ? 30 : 0);
   endtask

   always @(posedge clock) begin
      eval_result_type rr;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result value %h status %0d", $time,
                     rsp_tdata[63:0], rsp_tdata[66:64]);
            error_count++;
         end else begin
            rr = pending_results.pop_front();
            finish_count++;
            status_seen[rr.status]++;
            if (rsp_tdata[63:0] !== rr.value) begin
               $display("%0t: value expected %h actual %h", $time, rr.value, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tdata[66:64] !== rr.status) begin
               $display("%0t: status expected %0d actual %0d", $time, rr.status,
                        rsp_tdata[66:64]);
               error_count++;
            end
            if (rsp_tdata[71:67] !== '0) begin
               $display("%0t: padding expected 0 actual %h", $time, rsp_tdata[71:67]);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!stall_enable) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 99) < 5) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 40) rsp_tready <= 1'b1;
   end

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return MIN_VAL;
         1: return MAX_VAL;
         2: return 64'(signed'($urandom_range(0, 6)) - 3);
         3: return {32'h0, $urandom()};
         4: return -{32'h0, $urandom()};
         5: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic test_directed_cases();
      send_token(OP_PUSH, MAX_VAL);  send_token(OP_PUSH, 64'd1);
      send_token(OP_ADD, '0);        send_token(OP_FINISH, '0);
      send_token(OP_PUSH, MIN_VAL);  send_token(OP_PUSH, 64'd1);
      send_token(OP_SUB, '0);        send_token(OP_FINISH, '0);
      send_token(OP_PUSH, MIN_VAL);  send_token(OP_PUSH, '1);
      send_token(OP_DIV, '0);        send_token(OP_FINISH, '0);
      send_token(OP_PUSH, MIN_VAL);  send_token(OP_PUSH, '1);
      send_token(OP_MOD, '0);        send_token(OP_FINISH, '0);
      send_token(OP_PUSH, 64'd7);    send_token(OP_PUSH, '0);
      send_token(OP_DIV, '0);        send_token(OP_FINISH, '0);
      send_token(OP_PUSH, -64'sd7);  send_token(OP_PUSH, 64'd3);
      send_token(OP_MOD, '0);        send_token(OP_FINISH, '0);
   endtask

   task automatic test_operator_set();
      send_token(OP_PUSH, MAX_VAL);  send_token(OP_PUSH, MAX_VAL);
      send_token(OP_MUL, '0);        send_token(OP_FINISH, '0);
      send_token(OP_PUSH, -64'sd1);  send_token(OP_PUSH, MAX_VAL);
      send_token(OP_MOD, '0);        send_token(OP_FINISH, '0);
      send_token(OP_PUSH, 64'd5);    send_token(OP_ADD, '0);
      send_token(OP_FINISH, '0);     send_token(OP_UNUSED, '1);
      send_token(OP_PUSH, 64'd1);    send_token(OP_PUSH, 64'd2);
      send_token(OP_FINISH, '0);     send_token(OP_FINISH, '0);
      send_token(OP_PUSH, 64'd6);    send_token(OP_PUSH, -64'sd4);
      send_token(OP_MUL, '0);        send_token(OP_PUSH, 64'd5);
      send_token(OP_DIV, '0);        send_token(OP_FINISH, '0);
   endtask

   task automatic test_stack_full();
      for (int i = 0; i < DEPTH; i++) send_token(OP_PUSH, 64'(i));
      send_token(OP_PUSH, 64'd99);
      send_token(OP_FINISH, '0);
      for (int i = 0; i < DEPTH; i++) send_token(OP_PUSH, 64'(i + 1));
      for (int i = 1; i < DEPTH; i++) send_token(OP_ADD, '0);
      send_token(OP_FINISH, '0);
   endtask

   task automatic test_random_expressions(int budget);
      int depth, len;
      logic [2:0] op;
      while (budget > 0) begin
         depth = 0;
         len   = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            if (depth < 2 || $urandom_range(0, 2) == 0) begin
               send_token(OP_PUSH, rand_operand());
               depth++;
            end else begin
               op = 3'($urandom_range(OP_ADD, OP_MOD));
               // keep divides sparse, they are slow
               if (op >= OP_DIV && $urandom_range(0, 2) != 0) op = OP_ADD;
               send_token(op, {$urandom(), $urandom()});
               depth--;
            end
            budget--;
         end
         while (depth > 1 && $urandom_range(0, 4) != 0) begin
            send_token(3'($urandom_range(OP_ADD, OP_MUL)), '0);
            depth--;
            budget--;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_token(3'($urandom_range(0, 7)), {$urandom(), $urandom()});
            budget--;
         end
         send_token(OP_FINISH, {$urandom(), $urandom()});
         budget--;
      end
   endtask

   initial begin
      error_count  = 0;
      token_count  = 0;
      finish_count = 0;
      eval_depth   = 0;
      eval_error   = ST_OK;
      stall_enable = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      stall_enable = 1'b1;
      test_operator_set();
      test_stack_full();
      test_random_expressions(200);
      stall_enable = 1'b0;
      test_random_expressions(80);
      stall_enable = 1'b1;
      test_random_expressions(180);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("tokens sent %0d, results checked %0d", token_count, finish_count);
      $display("status counts ok %0d malformed %0d overflow %0d divzero %0d full %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("FAIL");
      $finish;
   end

endmodule
